>>> hdl/fcrg_pkg.sv
// ----------------------------------------------------------------------------
// fcrg_pkg
// types, constants and constant functions of the false-colour ramp generator
// ----------------------------------------------------------------------------
`default_nettype none

package fcrg_pkg;

   // field and register widths
   localparam int LEN_W   = 9;
   localparam int MODE_W  = 3;
   localparam int IDX_W   = 8;
   localparam int LEVEL_W = 16;
   localparam int NUM_W   = 24;
   localparam int RECIP_W = 33;
   localparam int CSR_W   = 1;

   localparam int MAX_ENTRIES_DEF = 256;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_RAMP_LENGTH = 1'b0;
   localparam logic [CSR_W-1:0] CSR_RAMP_MODE   = 1'b1;

   localparam logic [LEN_W-1:0]  LEN_RESET  = 9'd151;

   // ramp modes
   localparam logic [MODE_W-1:0] MODE_NORMAL    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PERIODIC  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HOT       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COOL      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REDBLUE   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_GRAY      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CUBEHELIX = 3'd6;

   // segments of the hot ramp
   localparam logic [1:0] SEG_LOW = 2'd0;
   localparam logic [1:0] SEG_MID = 2'd1;
   localparam logic [1:0] SEG_TOP = 2'd2;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'd65280;

   // rainbow constants (q16)
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [16:0] THIRD_LO    = 17'd21845;
   localparam logic [16:0] THIRD_HI    = 17'd21846;
   localparam logic [16:0] TWO_THIRDS  = 17'd43691;
   localparam logic [16:0] BLUE_TOP    = 17'd68813;
   localparam logic [31:0] RAIN_SCALE  = 32'd765;
   localparam logic [47:0] BLUE_SCALE  = 48'd46625587;

   // cubehelix constants
   localparam logic [31:0] AMP_GAIN    = 32'd39322;
   localparam logic [17:0] PHASE_BASE  = 18'd207531;
   localparam logic signed [17:0] COEF_RC = -18'sd9739;
   localparam logic signed [17:0] COEF_RS = 18'sd116836;
   localparam logic signed [17:0] COEF_GC = -18'sd19154;
   localparam logic signed [17:0] COEF_GS = -18'sd59408;
   localparam logic signed [17:0] COEF_BC = 18'sd129299;

   localparam int QS_DEPTH = 257;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] res;
   } sqrt_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               beyond;
      logic [15:0]        x;
      logic [LEVEL_W-1:0] flat_r;
      logic [LEVEL_W-1:0] flat_g;
      logic [LEVEL_W-1:0] flat_b;
      logic               rz;
      logic               gz;
      logic               bz;
   } carry_type;

   // quarter wave of sine in q0.15, taylor series to the 11th power in q30
   function automatic logic [14:0] quarter_sin(input int unsigned r);
      logic [63:0] th;
      logic [63:0] th2;
      logic [63:0] term;
      longint      sum;
      th   = 64'(r) * 64'd6588397;
      th2  = (th * th) >> 30;
      sum  = longint'(th);
      term = ((th * th2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * th2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * th2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * th2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * th2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      return 15'(sum);
   endfunction

   // four steps of the bit-pair square root recurrence
   function automatic sqrt_type sqrt_step4(input sqrt_type s_in, input int unsigned first);
      sqrt_type    s;
      logic [31:0] bitv;
      logic [31:0] trial;
      s = s_in;
      for (int j = 0; j < 4; j++) begin
         bitv  = 32'd1 << (30 - 2 * (int'(first) + j));
         trial = s.res + bitv;
         if (s.rem >= trial) begin
            s.rem = s.rem - trial;
            s.res = (s.res >> 1) + bitv;
         end else begin
            s.res = s.res >> 1;
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hdl/false_colour_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// false_colour_ramp_generator_top
// maps a ramp entry index to the 16-bit rgb levels of a false-colour ramp
// ----------------------------------------------------------------------------
// throughput: one item per cycle when rsp_tready does not stall it, set by the
//   ten-stage pipeline with a valid bit per stage; a stalled stage holds while
//   bubbles behind it fill
// reset: synchronous, clears all stage valid bits, ramp_length to 151 and
//   ramp_mode to normal
`default_nettype none

module false_colour_ramp_generator_top #(
   parameter int MAX_ENTRIES = fcrg_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] entry_index
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] red, [31:16] green, [47:32] blue
   output logic [0:0]       rsp_tuser,   // [0] beyond_ramp
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int LW       = fcrg_pkg::LEN_W;
   localparam int NW       = fcrg_pkg::NUM_W;
   localparam int NS       = 10;
   // reciprocal table covers every divisor the ramp length can reach
   localparam int RT_DEPTH = ((MAX_ENTRIES < 511) ? MAX_ENTRIES : 511) + 1;
   localparam int RT_IW    = $clog2(RT_DEPTH);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [LW-1:0] ramp_length_ff, ramp_length_in;
   logic [2:0]    ramp_mode_ff, ramp_mode_in;

   assign csr_ready = 1'b1;

   always_comb begin
      ramp_length_in = ramp_length_ff;
      ramp_mode_in   = ramp_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fcrg_pkg::CSR_RAMP_LENGTH: ramp_length_in = csr_data;
            fcrg_pkg::CSR_RAMP_MODE:   ramp_mode_in   = csr_data[2:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_length_ff <= fcrg_pkg::LEN_RESET;
         ramp_mode_ff   <= fcrg_pkg::MODE_NORMAL;
      end else begin
         ramp_length_ff <= ramp_length_in;
         ramp_mode_ff   <= ramp_mode_in;
      end
   end

   // ------------------------------------------------------------------
   // constant tables: floor(2^32 / d) and the quarter sine wave
   // ------------------------------------------------------------------
   logic [fcrg_pkg::RECIP_W-1:0] recip_tab [RT_DEPTH];
   logic [14:0]                  qsin_tab [fcrg_pkg::QS_DEPTH];

   for (genvar g = 0; g < RT_DEPTH; g++) begin : g_recip
      localparam logic [fcrg_pkg::RECIP_W-1:0] RV =
         (g == 0) ? '1 : fcrg_pkg::RECIP_W'((64'd1 << 32) / g);
      assign recip_tab[g] = RV;
   end

   for (genvar g = 0; g < fcrg_pkg::QS_DEPTH; g++) begin : g_qsin
      localparam logic [14:0] QV = fcrg_pkg::quarter_sin(g);
      assign qsin_tab[g] = QV;
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when empty or when the next
   // one loads, so bubbles are squeezed out during a stall
   // ------------------------------------------------------------------
   logic [NS-1:0] v_ff, v_in, en;

   always_comb begin
      en[NS-1] = ~v_ff[NS-1] | rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
      v_in = {v_ff[NS-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NS-1];

   // ------------------------------------------------------------------
   // stage 0: range check, hot segments, pick dividend and divisor
   // ------------------------------------------------------------------
   logic [LW-1:0] n_sat, idx_ext, hot_a, hot_b, hot_c, hot_m;
   logic [10:0]   n_x3;
   logic [NW-1:0] s0_num_ff, s0_num_in;
   logic [LW-1:0] s0_den_ff, s0_den_in;
   logic [2:0]    s0_mode_ff;
   logic          s0_beyond_ff, s0_beyond_in;
   logic [1:0]    s0_seg_ff, s0_seg_in;

   always_comb begin
      if (int'(ramp_length_ff) > MAX_ENTRIES) n_sat = LW'(MAX_ENTRIES);
      else n_sat = ramp_length_ff;
      idx_ext      = {1'b0, req_tdata};
      s0_beyond_in = idx_ext >= n_sat;
      // hot segments: a = 3n/8, b = 2a, c = n - b
      n_x3  = 11'(n_sat) * 11'd3;
      hot_a = LW'(n_x3 >> 3);
      hot_b = hot_a << 1;
      hot_c = n_sat - hot_b;
      if (idx_ext < hot_a) begin
         s0_seg_in = fcrg_pkg::SEG_LOW;
         hot_m     = idx_ext;
      end else if (idx_ext < hot_b) begin
         s0_seg_in = fcrg_pkg::SEG_MID;
         hot_m     = idx_ext - hot_a;
      end else begin
         s0_seg_in = fcrg_pkg::SEG_TOP;
         hot_m     = idx_ext - hot_b;
      end
      case (ramp_mode_ff)
         fcrg_pkg::MODE_HOT: begin
            s0_num_in = NW'(hot_m[7:0]) * NW'(fcrg_pkg::FULL_LEVEL);
            s0_den_in = (s0_seg_in == fcrg_pkg::SEG_TOP) ? hot_c : hot_a;
         end
         fcrg_pkg::MODE_GRAY: begin
            s0_num_in = NW'(req_tdata) * NW'(fcrg_pkg::FULL_LEVEL);
            s0_den_in = n_sat;
         end
         default: begin
            // x = i * 2^16 / n
            s0_num_in = {req_tdata, 16'h0000};
            s0_den_in = n_sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_num_ff    <= s0_num_in;
         s0_den_ff    <= s0_den_in;
         s0_mode_ff   <= ramp_mode_ff;
         s0_beyond_ff <= s0_beyond_in;
         s0_seg_ff    <= s0_seg_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: quotient estimate through the reciprocal, low by at most one
   // ------------------------------------------------------------------
   logic [56:0]   recip_prod;
   logic [NW-1:0] s1_num_ff, s1_qe_ff;
   logic [LW-1:0] s1_den_ff;
   logic [2:0]    s1_mode_ff;
   logic          s1_beyond_ff;
   logic [1:0]    s1_seg_ff;

   assign recip_prod = 57'(s0_num_ff) * 57'(recip_tab[s0_den_ff[RT_IW-1:0]]);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_num_ff    <= s0_num_ff;
         s1_den_ff    <= s0_den_ff;
         s1_qe_ff     <= recip_prod[55:32];
         s1_mode_ff   <= s0_mode_ff;
         s1_beyond_ff <= s0_beyond_ff;
         s1_seg_ff    <= s0_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: remainder check and quotient correction
   // ------------------------------------------------------------------
   logic [32:0]   qd_prod;
   logic [NW-1:0] rem_est, q_fix;
   logic [15:0]   s2_x_ff;
   logic [2:0]    s2_mode_ff;
   logic          s2_beyond_ff;
   logic [1:0]    s2_seg_ff;

   always_comb begin
      qd_prod = 33'(s1_qe_ff) * 33'(s1_den_ff);
      rem_est = s1_num_ff - qd_prod[NW-1:0];
      q_fix   = (rem_est >= NW'(s1_den_ff)) ? s1_qe_ff + NW'(1) : s1_qe_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_x_ff      <= q_fix[15:0];
         s2_mode_ff   <= s1_mode_ff;
         s2_beyond_ff <= s1_beyond_ff;
         s2_seg_ff    <= s1_seg_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: rainbow radicands, helix amplitude product and phase,
   // levels of the simple ramps
   // ------------------------------------------------------------------
   logic [16:0]         x17, y17, v17, nx17;
   logic [31:0]         prod_in [3];
   logic [31:0]         hp, cool_rp, cool_bp;
   logic [17:0]         ph18;
   fcrg_pkg::carry_type car_in0;
   logic [31:0]         s3_prod_ff [3];
   logic [14:0]         s3_hp_ff;
   logic [9:0]          s3_phase_ff;
   fcrg_pkg::carry_type car_ff [6];

   always_comb begin
      x17  = {1'b0, s2_x_ff};
      nx17 = fcrg_pkg::ONE_Q16 - x17;
      y17  = (s2_mode_ff == fcrg_pkg::MODE_NORMAL) ? nx17 : x17;
      v17  = (s2_mode_ff == fcrg_pkg::MODE_PERIODIC && y17 >= fcrg_pkg::TWO_THIRDS)
             ? fcrg_pkg::ONE_Q16 - y17 : y17;

      car_in0.mode   = s2_mode_ff;
      car_in0.beyond = s2_beyond_ff;
      car_in0.x      = s2_x_ff;
      car_in0.rz     = v17 >= fcrg_pkg::THIRD_HI;
      car_in0.gz     = y17 >= fcrg_pkg::TWO_THIRDS;
      car_in0.bz     = y17 <= fcrg_pkg::THIRD_LO;

      prod_in[0] = car_in0.rz ? '0 :
         32'(fcrg_pkg::THIRD_LO - v17) * 32'(v17 + fcrg_pkg::THIRD_HI);
      prod_in[1] = car_in0.gz ? '0 :
         32'(fcrg_pkg::TWO_THIRDS - y17) * 32'(y17);
      prod_in[2] = car_in0.bz ? '0 :
         32'(fcrg_pkg::BLUE_TOP - y17) * 32'(y17 - fcrg_pkg::THIRD_LO);

      // helix: x(1-x) and phase in turns
      hp   = 32'(x17) * 32'(nx17);
      ph18 = fcrg_pkg::PHASE_BASE - ((18'(x17) * 18'd3) >> 1);

      cool_rp = 32'(x17) * 32'(fcrg_pkg::FULL_LEVEL);
      cool_bp = 32'(nx17) * 32'(fcrg_pkg::FULL_LEVEL);

      car_in0.flat_r = '0;
      car_in0.flat_g = '0;
      car_in0.flat_b = '0;
      case (s2_mode_ff) inside
         fcrg_pkg::MODE_HOT: begin
            case (s2_seg_ff)
               fcrg_pkg::SEG_LOW: begin
                  car_in0.flat_r = s2_x_ff;
               end
               fcrg_pkg::SEG_MID: begin
                  car_in0.flat_r = fcrg_pkg::FULL_LEVEL;
                  car_in0.flat_g = s2_x_ff;
               end
               default: begin
                  car_in0.flat_r = fcrg_pkg::FULL_LEVEL;
                  car_in0.flat_g = fcrg_pkg::FULL_LEVEL;
                  car_in0.flat_b = s2_x_ff;
               end
            endcase
         end
         fcrg_pkg::MODE_COOL, fcrg_pkg::MODE_REDBLUE: begin
            car_in0.flat_r = cool_rp[31:16];
            car_in0.flat_b = cool_bp[31:16];
            car_in0.flat_g = (s2_mode_ff == fcrg_pkg::MODE_COOL) ? fcrg_pkg::FULL_LEVEL : '0;
         end
         fcrg_pkg::MODE_GRAY: begin
            car_in0.flat_r = s2_x_ff;
            car_in0.flat_g = s2_x_ff;
            car_in0.flat_b = s2_x_ff;
         end
         default: begin
            car_in0.flat_r = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int c = 0; c < 3; c++) s3_prod_ff[c] <= prod_in[c];
         s3_hp_ff    <= hp[30:16];
         s3_phase_ff <= ph18[15:6];
         car_ff[0]   <= car_in0;
      end
   end

   // side fields ride along stages 4 to 8
   always_ff @(posedge clock) begin
      for (int k = 1; k < 6; k++) begin
         if (en[k+3]) car_ff[k] <= car_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // stages 4 to 7: square roots, four result bits per stage
   // ------------------------------------------------------------------
   fcrg_pkg::sqrt_type sq_in [4][3];
   fcrg_pkg::sqrt_type sq_ff [4][3];
   fcrg_pkg::sqrt_type sq_seed;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_seed.rem = s3_prod_ff[c];
         sq_seed.res = '0;
         sq_in[0][c] = fcrg_pkg::sqrt_step4(sq_seed, 0);
         for (int k = 1; k < 4; k++) begin
            sq_in[k][c] = fcrg_pkg::sqrt_step4(sq_ff[k-1][c], 4 * k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (en[k+4]) begin
            for (int c = 0; c < 3; c++) sq_ff[k][c] <= sq_in[k][c];
         end
      end
   end

   // ------------------------------------------------------------------
   // stages 4 to 8: cubehelix
   // ------------------------------------------------------------------
   logic [31:0]        amp_prod;
   logic [1:0]         quad_s, quad_c;
   logic [9:0]         cos_idx;
   logic [8:0]         ridx_s, ridx_c;
   logic [14:0]        mag_s, mag_c;
   logic [13:0]        s4_amp_ff;
   logic signed [15:0] s4_sin_ff, s4_cos_ff, sin_in, cos_in;
   logic signed [35:0] mix_in [3];
   logic signed [35:0] s5_mix_ff [3];
   logic [13:0]        s5_amp_ff;
   logic signed [51:0] amp_mix [3];
   logic signed [16:0] s6_sh_ff [3];
   logic signed [18:0] c_sum [3];
   logic [16:0]        c_in [3];
   logic [16:0]        s7_c_ff [3];
   logic [31:0]        helix_prod [3];
   logic [15:0]        s8_helix_ff [3];

   always_comb begin
      amp_prod = 32'(s3_hp_ff) * fcrg_pkg::AMP_GAIN;
      // sine from the quarter table, mirrored and negated by quadrant
      cos_idx = s3_phase_ff + 10'd256;
      quad_s  = s3_phase_ff[9:8];
      quad_c  = cos_idx[9:8];
      ridx_s  = quad_s[0] ? 9'd256 - {1'b0, s3_phase_ff[7:0]} : {1'b0, s3_phase_ff[7:0]};
      ridx_c  = quad_c[0] ? 9'd256 - {1'b0, cos_idx[7:0]} : {1'b0, cos_idx[7:0]};
      mag_s   = qsin_tab[ridx_s];
      mag_c   = qsin_tab[ridx_c];
      sin_in  = quad_s[1] ? -signed'({1'b0, mag_s}) : signed'({1'b0, mag_s});
      cos_in  = quad_c[1] ? -signed'({1'b0, mag_c}) : signed'({1'b0, mag_c});
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_amp_ff <= amp_prod[29:16];
         s4_sin_ff <= sin_in;
         s4_cos_ff <= cos_in;
      end
   end

   always_comb begin
      mix_in[0] = fcrg_pkg::COEF_RC * s4_cos_ff + fcrg_pkg::COEF_RS * s4_sin_ff;
      mix_in[1] = fcrg_pkg::COEF_GC * s4_cos_ff + fcrg_pkg::COEF_GS * s4_sin_ff;
      mix_in[2] = fcrg_pkg::COEF_BC * s4_cos_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int c = 0; c < 3; c++) s5_mix_ff[c] <= mix_in[c];
         s5_amp_ff <= s4_amp_ff;
      end
   end

   // floor(amp * mix / 2^31) is the arithmetic shift of the product
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         amp_mix[c] = signed'({1'b0, s5_amp_ff}) * s5_mix_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int c = 0; c < 3; c++) s6_sh_ff[c] <= amp_mix[c][47:31];
      end
   end

   // add x and clamp to 0..1
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         c_sum[c] = signed'({3'b000, car_ff[3].x}) + 19'(s6_sh_ff[c]);
         if (c_sum[c] < 0) c_in[c] = '0;
         else if (c_sum[c] > 19'sd65536) c_in[c] = fcrg_pkg::ONE_Q16;
         else c_in[c] = c_sum[c][16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int c = 0; c < 3; c++) s7_c_ff[c] <= c_in[c];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         helix_prod[c] = 32'(s7_c_ff[c]) * 32'(fcrg_pkg::FULL_LEVEL);
      end
   end

   // ------------------------------------------------------------------
   // stage 8: rainbow scaling with saturation to 255
   // ------------------------------------------------------------------
   logic [31:0] rain_prod [2];
   logic [47:0] blue_prod;
   logic [7:0]  rain_in [3];
   logic [7:0]  s8_rain_ff [3];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         rain_prod[c] = 32'(sq_ff[3][c].res[15:0]) * fcrg_pkg::RAIN_SCALE;
         rain_in[c]   = (rain_prod[c][31:16] > 16'd255) ? 8'hff : rain_prod[c][23:16];
      end
      blue_prod  = 48'(sq_ff[3][2].res[15:0]) * fcrg_pkg::BLUE_SCALE;
      rain_in[2] = (blue_prod[47:32] > 16'd255) ? 8'hff : blue_prod[39:32];
      if (car_ff[4].rz) rain_in[0] = '0;
      if (car_ff[4].gz) rain_in[1] = '0;
      if (car_ff[4].bz) rain_in[2] = '0;
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int c = 0; c < 3; c++) begin
            s8_rain_ff[c]  <= rain_in[c];
            s8_helix_ff[c] <= helix_prod[c][31:16];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 9: mode select and output register
   // ------------------------------------------------------------------
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff;

   always_comb begin
      case (car_ff[5].mode) inside
         fcrg_pkg::MODE_NORMAL, fcrg_pkg::MODE_PERIODIC: begin
            rsp_data_in = {s8_rain_ff[2], 8'h00, s8_rain_ff[1], 8'h00,
                           s8_rain_ff[0], 8'h00};
         end
         fcrg_pkg::MODE_CUBEHELIX: begin
            rsp_data_in = {s8_helix_ff[2], s8_helix_ff[1], s8_helix_ff[0]};
         end
         default: begin
            rsp_data_in = {car_ff[5].flat_b, car_ff[5].flat_g, car_ff[5].flat_r};
         end
      endcase
      // entries past the ramp read as black
      if (car_ff[5].beyond) rsp_data_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= car_ff[5].beyond;
      end
   end

   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the false-colour ramp generator: a stimulus table and random
// indexes over several ramp lengths and all modes, each result compared
// field by field with a typed colour or a predictor kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   localparam int LATENCY   = 10;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        beyond;
   } colour_type;

   typedef struct {
      logic [7:0]  index;
      logic        typed;   // expected colour typed in the row
      colour_type  colour;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   // configuration copy held by the predictor
   logic [8:0]  cur_length = fcrg_pkg::LEN_RESET;
   logic [2:0]  cur_mode   = fcrg_pkg::MODE_NORMAL;

   colour_type  pending_colours[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_on = 1'b1;

   false_colour_ramp_generator_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // quarter sine, taylor series in q30 rounded to q15
   function automatic longint sine_quarter(input int unsigned r);
      longint unsigned th, th2, term;
      longint          sum;
      bit              neg;
      th   = longint'(r) * 64'd6588397;
      th2  = (th * th) >> 30;
      term = th;
      sum  = longint'(th);
      neg  = 1'b1;
      for (int k = 2; k <= 10; k += 2) begin
         term = ((term * th2) >> 30) / longint'(k * (k + 1));
         if (neg) sum = sum - longint'(term);
         else sum = sum + longint'(term);
         neg = !neg;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      return sum;
   endfunction

   function automatic longint sine_table(input int unsigned k);
      int unsigned q, r;
      longint      mag;
      k   = k & 1023;
      q   = k >> 8;
      r   = k & 255;
      mag = q[0] ? sine_quarter(256 - r) : sine_quarter(r);
      return q[1] ? -mag : mag;
   endfunction

   function automatic int unsigned rainbow_red(input int unsigned y, input bit per);
      int unsigned     v;
      longint unsigned t;
      v = y;
      if (per && y >= 43691) v = 65536 - y;
      if (v >= 21846) return 0;
      t = (765 * int_sqrt(longint'(21845 - v) * longint'(v + 21846))) >> 16;
      return t > 255 ? 255 : int'(t);
   endfunction

   function automatic int unsigned rainbow_green(input int unsigned y);
      longint unsigned t;
      if (y >= 43691) return 0;
      t = (765 * int_sqrt(longint'(43691 - y) * longint'(y))) >> 16;
      return t > 255 ? 255 : int'(t);
   endfunction

   function automatic int unsigned rainbow_blue(input int unsigned y);
      longint unsigned t;
      if (y <= 21845) return 0;
      t = (64'd46625587 * int_sqrt(longint'(68813 - y) * longint'(y - 21845))) >> 32;
      return t > 255 ? 255 : int'(t);
   endfunction

   function automatic int unsigned helix_level(input int unsigned x, input longint amp,
                                               input longint mix);
      longint p, c;
      p = amp * mix;
      if (p >= 0) c = p >>> 31;
      else c = -((-p + 64'h7FFF_FFFF) >>> 31);
      c = longint'(x) + c;
      if (c < 0) c = 0;
      if (c > 65536) c = 65536;
      return int'((65280 * c) >> 16);
   endfunction

   function automatic colour_type ramp_colour(input logic [7:0] idx);
      colour_type      o;
      int unsigned     i, n, x, r, g, b, s1, s2, s3, ph;
      longint unsigned amp;
      longint          sn, cs;
      i = idx;
      n = (cur_length > 256) ? 256 : cur_length;
      r = 0; g = 0; b = 0;
      o = '0;
      if (i >= n) begin
         o.beyond = 1'b1;
         return o;
      end
      x = int'((longint'(i) << 16) / n);
      case (cur_mode)
         fcrg_pkg::MODE_NORMAL: begin
            r = rainbow_red(65536 - x, 1'b0) << 8;
            g = rainbow_green(65536 - x) << 8;
            b = rainbow_blue(65536 - x) << 8;
         end
         fcrg_pkg::MODE_PERIODIC: begin
            r = rainbow_red(x, 1'b1) << 8;
            g = rainbow_green(x) << 8;
            b = rainbow_blue(x) << 8;
         end
         fcrg_pkg::MODE_HOT: begin
            s1 = (3 * n) >> 3;
            s2 = 2 * s1;
            s3 = n - s2;
            if (i < s1) begin
               r = 65280 * i / s1;
            end else if (i < s2) begin
               r = 65280;
               g = 65280 * (i - s1) / s1;
            end else begin
               r = 65280;
               g = 65280;
               b = 65280 * (i - s2) / s3;
            end
         end
         fcrg_pkg::MODE_COOL, fcrg_pkg::MODE_REDBLUE: begin
            r = int'((longint'(65280) * x) >> 16);
            b = int'((longint'(65280) * (65536 - x)) >> 16);
            g = (cur_mode == fcrg_pkg::MODE_COOL) ? 65280 : 0;
         end
         fcrg_pkg::MODE_GRAY: begin
            r = 65280 * i / n;
            g = r;
            b = r;
         end
         fcrg_pkg::MODE_CUBEHELIX: begin
            amp = (64'd39322 * ((longint'(x) * (65536 - x)) >> 16)) >> 16;
            ph  = (76459 + 131072 - ((3 * x) >> 1)) & 16'hFFFF;
            sn  = sine_table(ph >> 6);
            cs  = sine_table((ph >> 6) + 256);
            r = helix_level(x, amp, -9739 * cs + 116836 * sn);
            g = helix_level(x, amp, -19154 * cs - 59408 * sn);
            b = helix_level(x, amp, 129299 * cs);
         end
         default: ;
      endcase
      o.red   = r[15:0];
      o.green = g[15:0];
      o.blue  = b[15:0];
      return o;
   endfunction

   // ------------------------------------------------------------------ checks

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
      error_count++;
   endtask

   // result side: random stall bursts, sampled at the rising edge
   always @(posedge clock) begin
      colour_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colours.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_colours.pop_front();
            if (rsp_tdata[15:0] !== want.red)
               report_mismatch("red", rsp_tdata[15:0], want.red);
            if (rsp_tdata[31:16] !== want.green)
               report_mismatch("green", rsp_tdata[31:16], want.green);
            if (rsp_tdata[47:32] !== want.blue)
               report_mismatch("blue", rsp_tdata[47:32], want.blue);
            if (rsp_tuser[0] !== want.beyond)
               report_mismatch("beyond_ramp", rsp_tuser[0], want.beyond);
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count >= MAX_CYCLE) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // --------------------------------------------------------------- drivers

   // one register write; csr_valid is dropped and the csr channel left quiet before the next drive
   task automatic write_csr(input logic [0:0] idx, input logic [8:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == fcrg_pkg::CSR_RAMP_LENGTH) cur_length = value;
      else cur_mode = value[2:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one item on the req side; the prediction is queued at acceptance
   task automatic send_index(input logic [7:0] idx, input bit typed,
                             input colour_type want);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata  <= idx;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_colours.push_back(typed ? want : ramp_colour(idx));
      @(negedge clock);
   endtask

   // wait for every expected transfer, then drain the pipeline before a write
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_colours.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   localparam colour_type ZERO_IN  = '{16'd0, 16'd0, 16'd0, 1'b0};
   localparam colour_type BEYOND   = '{16'd0, 16'd0, 16'd0, 1'b1};

   initial begin
      stim_row_type rows[$];
      logic [8:0] lengths[8];
      logic [8:0] len;
      lengths = '{9'd1, 9'd2, 9'd3, 9'd151, 9'd256, 9'd257, 9'd511, 9'd0};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, then extremes and odd cases
      rows.push_back('{8'd0, 1'b0, ZERO_IN});
      rows.push_back('{8'd150, 1'b0, ZERO_IN});
      rows.push_back('{8'd151, 1'b1, BEYOND});       // index at length
      rows.push_back('{8'd255, 1'b1, BEYOND});
      foreach (rows[k]) send_index(rows[k].index, rows[k].typed, rows[k].colour);
      drain_results();

      // every mode, including the undefined one, over the table of lengths
      for (int m = 0; m < 8; m++) begin
         write_csr(fcrg_pkg::CSR_RAMP_MODE, 9'(m));
         foreach (lengths[l]) begin
            write_csr(fcrg_pkg::CSR_RAMP_LENGTH, lengths[l]);
            send_index(8'd0, lengths[l] == 0, BEYOND);
            send_index(8'd1, 1'b0, ZERO_IN);
            send_index(8'd255, lengths[l] < 256, BEYOND);
            send_index(8'd170, 1'b0, ZERO_IN);
            send_index(8'h55, 1'b0, ZERO_IN);
            drain_results();
         end
      end

      // random phases: mostly indexes inside the ramp
      for (int p = 0; p < 32; p++) begin
         if (p >= 27) idle_on = 1'b0;
         case ($urandom_range(0, 5))
            0: len = 9'($urandom_range(1, 3));
            1: len = 9'd256;
            2: len = 9'($urandom_range(0, 511));
            default: len = 9'($urandom_range(1, 256));
         endcase
         write_csr(fcrg_pkg::CSR_RAMP_LENGTH, len);
         write_csr(fcrg_pkg::CSR_RAMP_MODE, 9'($urandom_range(0, 7)));
         repeat (40) begin
            if (len != 0 && $urandom_range(0, 7) != 0)
               send_index(8'($urandom_range(0, (len > 256 ? 256 : len) - 1)), 1'b0, ZERO_IN);
            else
               send_index(8'($urandom_range(0, 255)), 1'b0, ZERO_IN);
         end
         drain_results();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
